// ----- design/ltrg_pkg.sv -----
// ltrg_pkg: operation codes, sequencer states and generator constants
// for the lcg and twister random generator
// no dependencies
package ltrg_pkg;

    typedef enum logic [2:0] {
        OP_SEED      = 3'd0,
        OP_LCG_INT   = 3'd1,
        OP_LCG_FLOAT = 3'd2,
        OP_TW_INT    = 3'd3,
        OP_TW_FLOAT  = 3'd4
    } op_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SEED_MUL,
        S_SEED_ADD,
        S_LCG_MUL,
        S_LCG_ADD,
        S_RG_START,
        S_RG_LOAD,
        S_RG_NXT,
        S_RG_FAR,
        S_RG_WRITE,
        S_TW_READ,
        S_TW_USE,
        S_RESULT
    } state_t;

    localparam logic [31:0] LCG_MUL   = 32'd1664525;
    localparam logic [31:0] LCG_ADD   = 32'd1013904223;
    localparam logic [31:0] TW_MATRIX = 32'h9908_B0DF;
    localparam logic [31:0] TW_UPPER  = 32'h8000_0000;
    localparam logic [31:0] TW_LOWER  = 32'h7FFF_FFFF;
    localparam logic [31:0] FLOAT_ONE = 32'h3F80_0000;
    localparam logic [31:0] FRAC_MASK = 32'h007F_FFFF;

endpackage

// ----- design/lcg_and_twister_random_generator.sv -----
// lcg_and_twister_random_generator: top level, sequencer and datapath
// depends on ltrg_pkg and ltrg_ram
// the twister buffer lives in one ltrg_ram instance
//
// A request carries an opcode and a seed value. Seed (opcode 0) loads the
// seed and fills the buffer with BUFFER_WORDS successive lcg values, and
// gives no result. Lcg integer and lcg float draws pass through the shared
// multiplier, then the adder, then hand the result to the output register.
// Twister draws go through the single read port of the buffer ram; the draw
// that finds the buffer used up first regenerates it in place, with three
// ram accesses per word. Opcodes 5 to 7 are taken and dropped. Twister
// draws must follow at least one seed request. The result waits in an
// output register, so a new request is taken while it is stalled.
module lcg_and_twister_random_generator #(
    parameter int BUFFER_WORDS = 624,
    parameter int TWIST_OFFSET = 397
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  opcode,
    input  logic [31:0] seed_value,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] random_value
);

    import ltrg_pkg::*;

    localparam int AW      = $clog2(BUFFER_WORDS);
    localparam int PW      = $clog2(BUFFER_WORDS + 1);
    localparam int OFF_MOD = TWIST_OFFSET % BUFFER_WORDS;

    localparam logic [AW-1:0] LAST_IDX = AW'(BUFFER_WORDS - 1);
    localparam logic [PW-1:0] POS_END  = PW'(BUFFER_WORDS);

    state_t state_reg, state_next;

    logic [31:0]   seed_reg, seed_next;
    logic [PW-1:0] pos_reg, pos_next;
    logic          out_valid_reg, out_valid_next;

    logic [31:0]   prod_reg, prod_next;
    logic [31:0]   cur_reg, cur_next;
    logic [31:0]   nxt_word_reg, nxt_word_next;
    logic [31:0]   res_reg, res_next;
    logic [31:0]   out_data_reg, out_data_next;
    logic          float_reg, float_next;
    logic [AW-1:0] idx_reg, idx_next;
    logic [AW-1:0] nxt_idx_reg, nxt_idx_next;
    logic [AW-1:0] far_idx_reg, far_idx_next;

    logic          ram_wr_en;
    logic [AW-1:0] ram_wr_addr;
    logic [31:0]   ram_wr_data;
    logic [AW-1:0] ram_rd_addr;
    logic [31:0]   ram_rd_data;

    logic [31:0]   lcg_sum;
    logic [31:0]   mix_word;
    logic [31:0]   twist_word;
    logic [31:0]   frac;
    logic          in_take;
    logic          out_free;

    ltrg_ram #(
        .WIDTH (32),
        .DEPTH (BUFFER_WORDS)
    ) u_buffer (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign in_stall     = (state_reg != S_IDLE);
    assign out_valid    = out_valid_reg;
    assign random_value = out_data_reg;

    assign in_take  = in_valid && (state_reg == S_IDLE);
    assign out_free = !out_valid_reg || !out_stall;

    assign lcg_sum    = prod_reg + LCG_ADD;
    assign mix_word   = (cur_reg & TW_UPPER) | (nxt_word_reg & TW_LOWER);
    assign twist_word = ram_rd_data ^ (mix_word >> 1) ^ (mix_word[0] ? TW_MATRIX : '0);
    assign frac       = (ram_rd_data ^ seed_reg) & FRAC_MASK;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_take)
                begin
                    unique case (opcode) inside
                        OP_SEED:
                            state_next = S_SEED_MUL;
                        OP_LCG_INT, OP_LCG_FLOAT:
                            state_next = S_LCG_MUL;
                        OP_TW_INT, OP_TW_FLOAT:
                            state_next = (pos_reg >= POS_END) ? S_RG_START : S_TW_READ;
                        default:
                            state_next = S_IDLE;
                    endcase
                end
            end
            S_SEED_MUL:
                state_next = S_SEED_ADD;
            S_SEED_ADD:
                state_next = (idx_reg == LAST_IDX) ? S_IDLE : S_SEED_MUL;
            S_LCG_MUL:
                state_next = S_LCG_ADD;
            S_LCG_ADD:
                state_next = S_RESULT;
            S_RG_START:
                state_next = S_RG_LOAD;
            S_RG_LOAD:
                state_next = S_RG_FAR;
            S_RG_NXT:
                state_next = S_RG_FAR;
            S_RG_FAR:
                state_next = S_RG_WRITE;
            S_RG_WRITE:
                state_next = (idx_reg == LAST_IDX) ? S_TW_READ : S_RG_NXT;
            S_TW_READ:
                state_next = S_TW_USE;
            S_TW_USE:
                state_next = S_RESULT;
            S_RESULT:
                state_next = out_free ? S_IDLE : S_RESULT;
            default:
                state_next = S_IDLE;
        endcase
    end

    // datapath and ram control
    always_comb
    begin
        seed_next      = seed_reg;
        pos_next       = pos_reg;
        out_valid_next = out_valid_reg && out_stall;
        prod_next      = prod_reg;
        cur_next       = cur_reg;
        nxt_word_next  = nxt_word_reg;
        res_next       = res_reg;
        out_data_next  = out_data_reg;
        float_next     = float_reg;
        idx_next       = idx_reg;
        nxt_idx_next   = nxt_idx_reg;
        far_idx_next   = far_idx_reg;
        ram_wr_en      = 1'b0;
        ram_wr_addr    = idx_reg;
        ram_wr_data    = lcg_sum;
        ram_rd_addr    = '0;

        unique case (state_reg) inside
            S_IDLE:
            begin
                idx_next     = '0;
                nxt_idx_next = AW'(1);
                far_idx_next = AW'(OFF_MOD);
                float_next   = (opcode == OP_LCG_FLOAT) || (opcode == OP_TW_FLOAT);
                if (in_take && (opcode == OP_SEED))
                begin
                    seed_next = seed_value;
                end
            end
            S_SEED_MUL, S_LCG_MUL:
                prod_next = seed_reg * LCG_MUL;
            S_SEED_ADD:
            begin
                seed_next = lcg_sum;
                ram_wr_en = 1'b1;
                idx_next  = idx_reg + AW'(1);
                if (idx_reg == LAST_IDX)
                begin
                    pos_next = '0;
                end
            end
            S_LCG_ADD:
            begin
                seed_next = lcg_sum;
                res_next  = float_reg ? (lcg_sum & FRAC_MASK) : lcg_sum;
            end
            S_RG_START:
                ram_rd_addr = '0;
            S_RG_LOAD:
            begin
                cur_next    = ram_rd_data;
                ram_rd_addr = nxt_idx_reg;
            end
            S_RG_NXT:
                ram_rd_addr = nxt_idx_reg;
            S_RG_FAR:
            begin
                nxt_word_next = ram_rd_data;
                ram_rd_addr   = far_idx_reg;
            end
            S_RG_WRITE:
            begin
                ram_wr_en    = 1'b1;
                ram_wr_data  = twist_word;
                cur_next     = nxt_word_reg;
                idx_next     = idx_reg + AW'(1);
                nxt_idx_next = (nxt_idx_reg == LAST_IDX) ? '0 : nxt_idx_reg + AW'(1);
                far_idx_next = (far_idx_reg == LAST_IDX) ? '0 : far_idx_reg + AW'(1);
                if (idx_reg == LAST_IDX)
                begin
                    pos_next = '0;
                end
            end
            S_TW_READ:
                ram_rd_addr = pos_reg[AW-1:0];
            S_TW_USE:
            begin
                pos_next = pos_reg + PW'(1);
                if (float_reg)
                begin
                    seed_next = FLOAT_ONE | frac;
                    res_next  = frac;
                end
                else
                begin
                    seed_next = seed_reg ^ ram_rd_data;
                    res_next  = seed_reg ^ ram_rd_data;
                end
            end
            S_RESULT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = res_reg;
                end
            end
            default:
            begin
                ram_wr_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            seed_reg      <= '0;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            seed_reg      <= seed_next;
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg     <= prod_next;
        cur_reg      <= cur_next;
        nxt_word_reg <= nxt_word_next;
        res_reg      <= res_next;
        out_data_reg <= out_data_next;
        float_reg    <= float_next;
        idx_reg      <= idx_next;
        nxt_idx_reg  <= nxt_idx_next;
        far_idx_reg  <= far_idx_next;
    end

endmodule

// ----- design/ltrg_ram.sv -----
// ltrg_ram: generic single write port, single read port ram with
// registered read data
// no dependencies
module ltrg_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 624
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ----- sim/tb_lcg_and_twister_random_generator.sv -----
`timescale 1ns / 100ps
// tb_lcg_and_twister_random_generator: self-checking bench for the lcg and twister
// random generator; a scoreboard class predicts every draw, a task drives the block
// depends on ltrg_pkg and lcg_and_twister_random_generator

class twister_scoreboard;
    localparam int          WORDS   = 624;
    localparam int          OFFSET  = 397;
    localparam logic [31:0] MULT    = 32'd1664525;
    localparam logic [31:0] INC     = 32'd1013904223;
    localparam logic [31:0] MATRIX  = 32'h9908_B0DF;
    localparam logic [31:0] UPPER   = 32'h8000_0000;
    localparam logic [31:0] LOWER   = 32'h7FFF_FFFF;
    localparam logic [31:0] ONE_EXP = 32'h3F80_0000;
    localparam logic [31:0] FRAC    = 32'h007F_FFFF;

    logic [31:0] seed_reg;
    logic [31:0] words [WORDS];
    int          position;
    logic [31:0] expected_draws [$];
    int          mismatches;

    function new();
        seed_reg   = '0;
        position   = 0;
        mismatches = 0;
        foreach (words[i])
            words[i] = '0;
    endfunction

    function logic [31:0] lcg_next(logic [31:0] s);
        return s * MULT + INC;
    endfunction

    function logic [31:0] next_word();
        logic [31:0] mixed;
        if (position >= WORDS)
        begin
            for (int i = 0; i < WORDS; i++)
            begin
                mixed = (words[i] & UPPER) | (words[(i + 1) % WORDS] & LOWER);
                words[i] = words[(i + OFFSET) % WORDS] ^ (mixed >> 1)
                           ^ (mixed[0] ? MATRIX : 32'h0);
            end
            position = 0;
        end
        position++;
        return words[position - 1];
    endfunction

    function void note_request(logic [2:0] op, logic [31:0] value);
        logic [31:0] frac;
        case (op)
            ltrg_pkg::OP_SEED:
            begin
                seed_reg = value;
                for (int i = 0; i < WORDS; i++)
                begin
                    seed_reg = lcg_next(seed_reg);
                    words[i] = seed_reg;
                end
                position = 0;
            end
            ltrg_pkg::OP_LCG_INT:
            begin
                seed_reg = lcg_next(seed_reg);
                expected_draws.push_back(seed_reg);
            end
            ltrg_pkg::OP_LCG_FLOAT:
            begin
                seed_reg = lcg_next(seed_reg);
                expected_draws.push_back(seed_reg & FRAC);
            end
            ltrg_pkg::OP_TW_INT:
            begin
                seed_reg = seed_reg ^ next_word();
                expected_draws.push_back(seed_reg);
            end
            ltrg_pkg::OP_TW_FLOAT:
            begin
                frac = (next_word() ^ seed_reg) & FRAC;
                seed_reg = ONE_EXP | frac;
                expected_draws.push_back(frac);
            end
            default: ;
        endcase
    endfunction

    function void check_result(logic [31:0] actual);
        logic [31:0] want;
        if (expected_draws.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected random_value %h with no request pending", actual);
        end
        else
        begin
            want = expected_draws.pop_front();
            if (want !== actual)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("random_value mismatch: expected %h, got %h", want, actual);
            end
        end
    endfunction
endclass

module tb_lcg_and_twister_random_generator;
    import ltrg_pkg::*;

    localparam int RANDOM_ITEMS = 1825;
    localparam int OPCODE_SPACE = 8;
    localparam int LONG_HOLD    = 300;
    localparam int DRAIN_CYCLES = 3 * 624 + 40;

    logic        clk;
    logic        rst_n      = 1'b0;
    logic        in_valid   = 1'b0;
    logic        in_stall;
    logic [2:0]  opcode     = '0;
    logic [31:0] seed_value = '0;
    logic        out_valid;
    logic        out_stall  = 1'b0;
    logic [31:0] random_value;

    twister_scoreboard board;
    int requests_sent = 0;
    int results_seen  = 0;

    lcg_and_twister_random_generator dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .opcode       (opcode),
        .seed_value   (seed_value),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .random_value (random_value)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic send_request(input logic [2:0] op, input logic [31:0] value);
        int gap;
        gap = ((requests_sent % 200) >= 160) ? 0 : $urandom_range(0, 10);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        opcode     <= op;
        seed_value <= value;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        board.note_request(op, value);
        requests_sent++;
    endtask

    // receiver: random stalls, quiet stretches, and two long hold-offs
    initial
    begin
        int hold;
        wait (rst_n);
        forever
        begin
            if (results_seen == 50 || results_seen == 1000)
                hold = LONG_HOLD;
            else if ((results_seen % 200) >= 150)
                hold = 0;
            else
                hold = $urandom_range(0, 10);
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
            board.check_result(random_value);
            results_seen++;
        end
    end

    initial
    begin
        logic [2:0] code;
        int         session;
        int         run_len;
        int         pick;
        int         counted;
        board = new();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // draws from the reset seed, then unused opcodes and another lcg draw
        send_request(OP_LCG_INT, 32'hFFFF_FFFF);
        send_request(OP_LCG_FLOAT, 32'h0000_0000);
        for (int k = int'(OP_TW_FLOAT) + 1; k < OPCODE_SPACE; k++)
            send_request(3'(k), $urandom());
        send_request(OP_LCG_INT, $urandom());
        // extreme seeds, raw fill read back before any regeneration
        send_request(OP_SEED, 32'h0000_0000);
        send_request(OP_TW_INT, 32'hFFFF_FFFF);
        send_request(OP_TW_FLOAT, $urandom());
        send_request(OP_LCG_INT, $urandom());
        send_request(OP_LCG_FLOAT, $urandom());
        send_request(OP_SEED, 32'hFFFF_FFFF);
        send_request(OP_TW_FLOAT, 32'h0000_0000);
        send_request(OP_TW_INT, $urandom());
        send_request(OP_TW_INT, $urandom());
        send_request(OP_SEED, 32'h8000_0000);
        send_request(OP_TW_FLOAT, $urandom());
        send_request(OP_LCG_FLOAT, $urandom());
        send_request(OP_SEED, 32'h7FFF_FFFF);
        send_request(OP_TW_INT, $urandom());
        send_request(OP_TW_FLOAT, $urandom());

        // sessions: a seed followed by draws; long ones run past the buffer end
        counted = 0;
        session = 0;
        while (counted < RANDOM_ITEMS)
        begin
            if (session == 0 || $urandom_range(0, 5) == 0)
                run_len = $urandom_range(1000, 1500);
            else
                run_len = $urandom_range(1, 40);
            send_request(OP_SEED, $urandom());
            counted++;
            for (int k = 0; k < run_len && counted < RANDOM_ITEMS; k++)
            begin
                pick = $urandom_range(0, (run_len > 40) ? 18 : 19);
                if (pick <= 6)
                    code = OP_TW_INT;
                else if (pick <= 13)
                    code = OP_TW_FLOAT;
                else if (pick <= 15)
                    code = OP_LCG_INT;
                else if (pick <= 17)
                    code = OP_LCG_FLOAT;
                else if (pick == 18)
                    code = 3'($urandom_range(int'(OP_TW_FLOAT) + 1, OPCODE_SPACE - 1));
                else
                    code = OP_SEED;
                send_request(code, $urandom());
                counted++;
            end
            session++;
        end
        in_valid <= 1'b0;

        while (board.expected_draws.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (board.mismatches == 0 && board.expected_draws.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        #200_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
